@@ rtl/core/tlcf_pkg.sv @@
`default_nettype none
package tlcf_pkg;

  // Columns of the line number; the counter holds this many BCD digits.
  localparam int NUM_DIGITS = 6;
  localparam int BCD_W      = 4 * NUM_DIGITS;

  // Output positions within one run: digits, then tab, prefix, byte.
  localparam int POS_COUNT = NUM_DIGITS + 3;
  localparam int POS_W     = $clog2(POS_COUNT);
  localparam int DIG_W     = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

  localparam logic [POS_W-1:0] POS_FIRST = '0;
  localparam logic [POS_W-1:0] POS_TAB   = POS_W'(NUM_DIGITS);
  localparam logic [POS_W-1:0] POS_PRE   = POS_W'(NUM_DIGITS + 1);
  localparam logic [POS_W-1:0] POS_BYTE  = POS_W'(NUM_DIGITS + 2);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_NUMBER_MODE    = 3'd0;
  localparam logic [2:0] REG_SQUEEZE_BLANKS = 3'd1;
  localparam logic [2:0] REG_CARET_CONTROLS = 3'd2;
  localparam logic [2:0] REG_MARK_LINE_ENDS = 3'd3;
  localparam logic [2:0] REG_CARET_TABS     = 3'd4;

  // Numbering modes.
  localparam logic [1:0] NUM_NONE  = 2'd0;
  localparam logic [1:0] NUM_ALL   = 2'd1;

  // Characters.
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_I      = 8'h49;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_DEL    = 8'h7F;
  localparam logic [7:0] CH_CTL_LIMIT = 8'h20;
  localparam logic [7:0] CARET_OFFSET = 8'h40;

  typedef struct packed {
    logic [1:0] number_mode;
    logic       squeeze_blanks;
    logic       caret_controls;
    logic       mark_line_ends;
    logic       caret_tabs;
  } cfg_t;

  // One classified input byte, waiting to be expanded into output bytes.
  typedef struct packed {
    logic             num_en;
    logic [BCD_W-1:0] bcd;
    logic             pre_en;
    logic [7:0]       pre_byte;
    logic [7:0]       data;
  } desc_t;

  // BCD increment that sticks at all nines.
  function automatic logic [BCD_W-1:0] bcd_inc_sat(input logic [BCD_W-1:0] v);
    logic [BCD_W-1:0] res;
    logic             full;
    logic             carry;
    logic [3:0]       d;
    res   = v;
    full  = 1'b1;
    carry = 1'b1;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (v[4*i +: 4] != 4'd9) begin
        full = 1'b0;
      end
    end
    for (int i = 0; i < NUM_DIGITS; i++) begin
      d = v[4*i +: 4];
      if (carry) begin
        if (d == 4'd9) begin
          res[4*i +: 4] = 4'd0;
        end else begin
          res[4*i +: 4] = d + 4'd1;
          carry = 1'b0;
        end
      end
    end
    return full ? v : res;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/tlcf_front.sv @@
`default_nettype none
module tlcf_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire tlcf_pkg::cfg_t cfg,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  input  wire logic [7:0]     in_tdata,
  input  wire logic           in_tuser,
  input  wire logic           q_full,
  output logic                push,
  output tlcf_pkg::desc_t     push_desc
);

  logic                       at_line_start_r, at_line_start_nxt;
  logic                       blank_seen_r, blank_seen_nxt;
  logic [tlcf_pkg::BCD_W-1:0] count_r, count_nxt;

  logic                       als, bs, nl, squeeze, num_en, accept;
  logic [tlcf_pkg::BCD_W-1:0] cnt;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    // A file start clears the line state before this byte is looked at.
    als = in_tuser ? 1'b1 : at_line_start_r;
    bs  = in_tuser ? 1'b0 : blank_seen_r;
    cnt = in_tuser ? '0   : count_r;
    nl  = (in_tdata == tlcf_pkg::CH_NL);

    squeeze = als && nl && cfg.squeeze_blanks && bs;

    blank_seen_nxt = bs;
    if (als) begin
      if (nl && cfg.squeeze_blanks) begin
        blank_seen_nxt = 1'b1;
      end else if (!nl) begin
        blank_seen_nxt = 1'b0;
      end
    end

    num_en = 1'b0;
    if (als && !squeeze) begin
      if (cfg.number_mode == tlcf_pkg::NUM_NONE) begin
        num_en = 1'b0;
      end else if (cfg.number_mode == tlcf_pkg::NUM_ALL) begin
        num_en = 1'b1;
      end else begin
        num_en = !nl;
      end
    end

    count_nxt         = num_en ? tlcf_pkg::bcd_inc_sat(cnt) : cnt;
    at_line_start_nxt = nl;

    push_desc.num_en   = num_en;
    push_desc.bcd      = count_nxt;
    push_desc.pre_en   = 1'b0;
    push_desc.pre_byte = tlcf_pkg::CH_CARET;
    push_desc.data     = in_tdata;
    if (cfg.caret_controls && !nl && (in_tdata != tlcf_pkg::CH_TAB)) begin
      if (in_tdata < tlcf_pkg::CH_CTL_LIMIT) begin
        push_desc.pre_en = 1'b1;
        push_desc.data   = in_tdata + tlcf_pkg::CARET_OFFSET;
      end else if (in_tdata >= tlcf_pkg::CH_DEL) begin
        push_desc.pre_en = 1'b1;
        push_desc.data   = in_tdata - tlcf_pkg::CARET_OFFSET;
      end
    end else if ((in_tdata == tlcf_pkg::CH_TAB) && cfg.caret_tabs) begin
      push_desc.pre_en = 1'b1;
      push_desc.data   = tlcf_pkg::CH_I;
    end
    if (cfg.mark_line_ends && nl) begin
      push_desc.pre_en   = 1'b1;
      push_desc.pre_byte = tlcf_pkg::CH_DOLLAR;
    end

    push = accept && !squeeze;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_line_start_r <= 1'b1;
      blank_seen_r    <= 1'b0;
      count_r         <= '0;
    end else if (accept) begin
      at_line_start_r <= at_line_start_nxt;
      blank_seen_r    <= blank_seen_nxt;
      count_r         <= count_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/tlcf_queue.sv @@
`default_nettype none
module tlcf_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire tlcf_pkg::desc_t push_desc,
  output logic                 full,
  input  wire logic            pop,
  output tlcf_pkg::desc_t      head,
  output logic                 empty
);

  tlcf_pkg::desc_t                 mem_r [tlcf_pkg::QUEUE_DEPTH];
  logic [tlcf_pkg::QPTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [tlcf_pkg::QPTR_W:0]       fill_r, fill_nxt;

  assign full  = (fill_r == (tlcf_pkg::QPTR_W+1)'(tlcf_pkg::QUEUE_DEPTH));
  assign empty = (fill_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    fill_nxt = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      fill_r <= fill_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/tlcf_back.sv @@
`default_nettype none
module tlcf_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire tlcf_pkg::desc_t head,
  input  wire logic            q_empty,
  output logic                 pop,
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  output logic [7:0]           out_tdata,
  output logic                 out_tlast
);

  logic                       started_r, started_nxt;
  logic [tlcf_pkg::POS_W-1:0] pos_r, pos_nxt, pos, first_pos;
  logic [7:0]                 digit_chars [tlcf_pkg::NUM_DIGITS];
  logic                       lead, xfer;
  logic [3:0]                 d;

  always_comb begin
    lead = 1'b1;
    for (int k = tlcf_pkg::NUM_DIGITS - 1; k >= 0; k--) begin
      d = head.bcd[4*k +: 4];
      if ((d == 4'd0) && lead && (k > 0)) begin
        digit_chars[tlcf_pkg::NUM_DIGITS-1-k] = tlcf_pkg::CH_SPACE;
      end else begin
        lead = 1'b0;
        digit_chars[tlcf_pkg::NUM_DIGITS-1-k] = tlcf_pkg::CH_ZERO + {4'd0, d};
      end
    end
  end

  always_comb begin
    if (head.num_en) begin
      first_pos = tlcf_pkg::POS_FIRST;
    end else if (head.pre_en) begin
      first_pos = tlcf_pkg::POS_PRE;
    end else begin
      first_pos = tlcf_pkg::POS_BYTE;
    end
    pos = started_r ? pos_r : first_pos;

    if (pos < tlcf_pkg::POS_TAB) begin
      out_tdata = digit_chars[pos[tlcf_pkg::DIG_W-1:0]];
    end else if (pos == tlcf_pkg::POS_TAB) begin
      out_tdata = tlcf_pkg::CH_TAB;
    end else if (pos == tlcf_pkg::POS_PRE) begin
      out_tdata = head.pre_byte;
    end else begin
      out_tdata = head.data;
    end

    out_tvalid = !q_empty;
    out_tlast  = (pos == tlcf_pkg::POS_BYTE);
    xfer       = out_tvalid && out_tready;
    pop        = xfer && out_tlast;

    started_nxt = started_r;
    pos_nxt     = pos_r;
    if (xfer) begin
      started_nxt = !out_tlast;
      if (pos == tlcf_pkg::POS_TAB) begin
        pos_nxt = head.pre_en ? tlcf_pkg::POS_PRE : tlcf_pkg::POS_BYTE;
      end else if (pos == tlcf_pkg::POS_PRE) begin
        pos_nxt = tlcf_pkg::POS_BYTE;
      end else begin
        pos_nxt = pos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
      pos_r     <= '0;
    end else begin
      started_r <= started_nxt;
      pos_r     <= pos_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/text_line_number_and_caret_filter_top.sv @@
// Text line numbering and caret display filter. Each input transfer carries one text
// byte and a file-start flag, and every input byte is accepted as long as the
// four-entry queue between the classifier and the expander has room. One input
// byte expands into one to nine output bytes (an optional six-column right-justified
// line number and a tab, an optional caret or dollar prefix, and the byte itself);
// the expander sends one output byte per cycle while out_tready is high, and takes
// the next queued entry only once the last byte of the current one is sent, so the
// sustained input rate is one byte per cycle for plain text with no output stall
// and lower when bytes expand. A newline dropped as a repeated blank line is accepted
// and produces nothing. out_tlast marks the final output byte of each input byte.
// Configuration must be written over the APB-style port only while the filter is
// idle; the block itself does not enforce this. The line counter sticks at 999999.
`default_nettype none
module text_line_number_and_caret_filter_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input stream.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tuser,   // [0] file_start
  // Output stream.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [7:0] out_byte
  output logic             out_tlast,
  // Configuration port.
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  tlcf_pkg::cfg_t  cfg_r, cfg_nxt;
  tlcf_pkg::desc_t push_desc, head;
  logic            push, pop, q_full, q_empty, cfg_wr;
  logic [2:0]      reg_idx;

  // Register writes complete in the access phase; there are no wait states.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = cfg_paddr[4:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (reg_idx)
        tlcf_pkg::REG_NUMBER_MODE:    cfg_nxt.number_mode    = cfg_pwdata[1:0];
        tlcf_pkg::REG_SQUEEZE_BLANKS: cfg_nxt.squeeze_blanks = cfg_pwdata[0];
        tlcf_pkg::REG_CARET_CONTROLS: cfg_nxt.caret_controls = cfg_pwdata[0];
        tlcf_pkg::REG_MARK_LINE_ENDS: cfg_nxt.mark_line_ends = cfg_pwdata[0];
        tlcf_pkg::REG_CARET_TABS:     cfg_nxt.caret_tabs     = cfg_pwdata[0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      tlcf_pkg::REG_NUMBER_MODE:    cfg_prdata = {30'd0, cfg_r.number_mode};
      tlcf_pkg::REG_SQUEEZE_BLANKS: cfg_prdata = {31'd0, cfg_r.squeeze_blanks};
      tlcf_pkg::REG_CARET_CONTROLS: cfg_prdata = {31'd0, cfg_r.caret_controls};
      tlcf_pkg::REG_MARK_LINE_ENDS: cfg_prdata = {31'd0, cfg_r.mark_line_ends};
      tlcf_pkg::REG_CARET_TABS:     cfg_prdata = {31'd0, cfg_r.caret_tabs};
      default:                      cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // The front end tracks line state and the line counter, and decides for each
  // byte whether it is dropped, numbered or given a prefix.
  tlcf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .push      (push),
    .push_desc (push_desc)
  );

  // The queue lets input keep flowing while a long run is still being sent.
  tlcf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .full      (q_full),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty)
  );

  // The back end walks each queued entry one output byte per transfer.
  tlcf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_empty    (q_empty),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // A run that has started always continues until its last byte is sent.
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("output run broken before its last byte");

  // Nothing is offered in the first cycle after reset is released.
  a_quiet_after_reset: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_tvalid)
    else $error("output valid right after reset");

  // The queue can never look full and empty at once.
  a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_full && q_empty))
    else $error("queue full and empty together");

endmodule
`default_nettype wire

@@ tb/sv/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tlcf_pkg::*;

  // Numbering modes that the package leaves unnamed. Mode 3 is undefined and
  // must behave like the non-blank mode.
  localparam logic [1:0] NUM_NONBLANK = 2'd2;
  localparam logic [1:0] NUM_UNDEF    = 2'd3;

  // Register indexes past the end of the register map; writes there do nothing.
  localparam logic [2:0] REG_SPARE_LO = 3'd5;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  // Largest line number that fits in the number field; the counter sticks there.
  localparam int unsigned MAX_LINE = 10 ** NUM_DIGITS - 1;

  // Cycles allowed after the last expected byte for work that produces nothing
  // (a squeezed newline is accepted at the input but never enters the queue).
  localparam int SETTLE_CYCLES = 2 * POS_COUNT * QUEUE_DEPTH + 16;

  // Cycles without any transfer before the run is declared hung. The longest
  // legitimate quiet stretch is the deliberate receiver hold.
  localparam int QUIET_LIMIT = 3000;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
  } text_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_char_t;

  typedef enum logic [1:0] {
    RX_READY,
    RX_RANDOM,
    RX_PATTERN
  } rx_style_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] data_byte
  logic        in_tuser = 1'b0; // [0] file_start

  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // [7:0] out_byte
  logic        out_tlast;

  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  text_line_number_and_caret_filter_top DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #4 clk = ~clk;

  // Text bytes still to be sent; the head is the one on the bus while in_tvalid
  // is high, and it leaves the queue on the edge that completes its transfer.
  text_item_t  pending_items[$];

  // Output characters predicted but not yet seen on the output stream.
  out_char_t   expected_chars[$];

  int          mismatches = 0;

  // Shadow copy of the filter's registers and line state.
  logic [1:0]  shadow_mode = NUM_NONE;
  logic        shadow_squeeze = 1'b0;
  logic        shadow_caret = 1'b0;
  logic        shadow_dollar = 1'b0;
  logic        shadow_tabs = 1'b0;
  logic        at_bol = 1'b1;
  logic        last_kept_blank = 1'b0;
  int unsigned line_no = 0;

  // Knobs that the stimulus sequence turns between phases.
  int          sender_max_gap = 0;
  rx_style_t   rx_style = RX_READY;
  int          rx_hold_len = 0;
  int          rx_hold_req = 0;

  // Expand one accepted text byte into the characters the filter must send,
  // updating the line state exactly as the filter does.
  task automatic expand_text_byte(input logic [7:0] raw, input logic file_start);
    logic [7:0]  ch;
    logic        nl;
    logic        numbered;
    logic        leading;
    logic [3:0]  digs [NUM_DIGITS];
    int unsigned rest;
    logic [7:0]  run[$];
    ch = raw;
    nl = (raw == CH_NL);
    numbered = 1'b0;
    if (file_start) begin
      at_bol = 1'b1;
      last_kept_blank = 1'b0;
      line_no = 0;
    end
    if (at_bol) begin
      // A blank line right after a kept blank line vanishes without a trace,
      // and the line state stays as it was.
      if (nl && shadow_squeeze) begin
        if (last_kept_blank) begin
          return;
        end
        last_kept_blank = 1'b1;
      end else if (!nl) begin
        last_kept_blank = 1'b0;
      end
      numbered = (shadow_mode == NUM_ALL) || (shadow_mode >= NUM_NONBLANK && !nl);
    end
    at_bol = nl;
    if (numbered) begin
      if (line_no < MAX_LINE) begin
        line_no++;
      end
      rest = line_no;
      for (int i = 0; i < NUM_DIGITS; i++) begin
        digs[i] = 4'(rest % 10);
        rest = rest / 10;
      end
      // Right-justified: leading zeros become spaces, the units digit always shows.
      leading = 1'b1;
      for (int i = NUM_DIGITS - 1; i >= 0; i--) begin
        if (digs[i] == 4'd0 && leading && i > 0) begin
          run.push_back(CH_SPACE);
        end else begin
          leading = 1'b0;
          run.push_back(CH_ZERO + 8'(digs[i]));
        end
      end
      run.push_back(CH_TAB);
    end
    // Caret display never touches the tab; only the tab switch makes it ^I.
    if (shadow_caret && !nl && raw != CH_TAB) begin
      if (raw < CH_CTL_LIMIT) begin
        run.push_back(CH_CARET);
        ch = raw + CARET_OFFSET;
      end else if (raw >= CH_DEL) begin
        run.push_back(CH_CARET);
        ch = raw - CARET_OFFSET;
      end
    end else if (raw == CH_TAB && shadow_tabs) begin
      run.push_back(CH_CARET);
      ch = raw + CARET_OFFSET;
    end
    if (shadow_dollar && nl) begin
      run.push_back(CH_DOLLAR);
    end
    run.push_back(ch);
    foreach (run[i]) begin
      expected_chars.push_back('{out_byte: run[i], last_of_run: (i == run.size() - 1)});
    end
  endtask

  // Input driver. The head of pending_items is offered in bursts of random
  // length separated by random gaps; a gap of zero gives back-to-back traffic.
  // An offered byte stays on the bus until its transfer completes.
  int burst_left = 1;
  int gap_left = 0;
  logic offer_next;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expand_text_byte(in_tdata, in_tuser);
        void'(pending_items.pop_front());
      end
      if (!in_tvalid || in_tready) begin
        offer_next = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_items.size() > 0) begin
          offer_next = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 12);
            gap_left = (sender_max_gap == 0) ? 0 : $urandom_range(0, sender_max_gap);
          end
        end
        in_tvalid <= offer_next;
        if (offer_next) begin
          in_tdata <= pending_items[0].data_byte;
          in_tuser <= pending_items[0].file_start;
        end
      end
    end
  end

  // Output receiver. Its stall pattern is chosen per phase. A long hold,
  // requested by bumping rx_hold_req, is counted down here and overrides the
  // pattern so that the filter's queue fills and it stops taking input.
  int   rx_hold_seen = 0;
  int   rx_hold_left = 0;
  int   rx_tick = 0;
  logic ready_next;

  always @(posedge clk) begin
    if (rx_hold_seen != rx_hold_req) begin
      rx_hold_seen = rx_hold_req;
      rx_hold_left = rx_hold_len;
    end
    rx_tick++;
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      ready_next = 1'b0;
    end else begin
      case (rx_style)
        RX_READY: begin
          ready_next = 1'b1;
        end
        RX_RANDOM: begin
          ready_next = ($urandom_range(0, 99) < 55);
        end
        default: begin
          // Uneven period so that stalls slide across the digit, prefix and
          // byte positions of successive runs.
          ready_next = (rx_tick % 7 != 2) && (rx_tick % 11 > 1);
        end
      endcase
    end
    out_tready <= ready_next;
  end

  // Output checker: every transfer is compared with the oldest prediction.
  out_char_t seen_char;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected output transfer: out_byte=%h last_of_run=%b",
               out_tdata, out_tlast);
        mismatches++;
      end else begin
        seen_char = expected_chars.pop_front();
        if (out_tdata !== seen_char.out_byte) begin
          $error("out_byte: expected %h, actual %h", seen_char.out_byte, out_tdata);
          mismatches++;
        end
        if (out_tlast !== seen_char.last_of_run) begin
          $error("last_of_run: expected %b, actual %b", seen_char.last_of_run, out_tlast);
          mismatches++;
        end
      end
    end
  end

  // Hang detector: any transfer on either stream or the register port restarts it.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || cfg_psel || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL text_line_number_and_caret_filter_top");
      $finish;
    end
  end

  // One register write: setup cycle, then access cycle; the register takes the
  // value at the edge that closes the access cycle with pready high.
  task automatic cfg_write(input logic [2:0] index, input logic [31:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {index, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (index)
      REG_NUMBER_MODE:    shadow_mode = value[1:0];
      REG_SQUEEZE_BLANKS: shadow_squeeze = value[0];
      REG_CARET_CONTROLS: shadow_caret = value[0];
      REG_MARK_LINE_ENDS: shadow_dollar = value[0];
      REG_CARET_TABS:     shadow_tabs = value[0];
      default: ;
    endcase
  endtask

  // Write all five registers; the unused upper bits carry random junk that
  // the filter has to ignore.
  task automatic program_filter(input logic [1:0] mode, input logic squeeze,
                                input logic caret, input logic dollar, input logic tabs);
    logic [31:0] junk;
    junk = $urandom();
    cfg_write(REG_NUMBER_MODE, {junk[31:2], mode});
    junk = $urandom();
    cfg_write(REG_SQUEEZE_BLANKS, {junk[31:1], squeeze});
    junk = $urandom();
    cfg_write(REG_CARET_CONTROLS, {junk[31:1], caret});
    junk = $urandom();
    cfg_write(REG_MARK_LINE_ENDS, {junk[31:1], dollar});
    junk = $urandom();
    cfg_write(REG_CARET_TABS, {junk[31:1], tabs});
    @(negedge clk);
  endtask

  task automatic queue_byte(input logic [7:0] data_byte, input logic file_start);
    pending_items.push_back('{data_byte: data_byte, file_start: file_start});
  endtask

  // Text-like random bytes: many newlines so blank runs and squeezing occur,
  // tabs, printable characters, a share of arbitrary bytes, rare file starts.
  function automatic text_item_t random_text_item();
    text_item_t item;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      item.data_byte = CH_NL;
    end else if (pick < 33) begin
      item.data_byte = CH_TAB;
    end else if (pick < 55) begin
      item.data_byte = 8'($urandom_range(0, 255));
    end else begin
      item.data_byte = 8'($urandom_range(32, 126));
    end
    item.file_start = ($urandom_range(0, 29) == 0);
    return item;
  endfunction

  // Wait until every queued byte has been sent and every prediction met.
  task automatic wait_for_results();
    do @(negedge clk); while (pending_items.size() != 0 || expected_chars.size() != 0);
  endtask

  // Same, plus time for a trailing squeezed newline to clear the pipeline,
  // so that the filter is idle before registers change.
  task automatic wait_idle();
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: every line feature on at once except the tab switch, so that
    // a tab passes unchanged even though control bytes are shown in carets.
    // Covers repeated blank lines being dropped, every caret boundary, the
    // high bytes, and the nine-byte run of a numbered caret byte.
    program_filter(NUM_ALL, 1'b1, 1'b1, 1'b1, 1'b0);
    rx_style = RX_PATTERN;
    sender_max_gap = 3;
    queue_byte("A", 1'b1);
    queue_byte(CH_NL, 1'b0);
    queue_byte(CH_NL, 1'b0);
    queue_byte(CH_NL, 1'b0);
    queue_byte(CH_NL, 1'b0);
    queue_byte("x", 1'b0);
    queue_byte(CH_TAB, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h1F, 1'b0);
    queue_byte(CH_DEL, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(CH_SPACE, 1'b0);
    queue_byte(8'h7E, 1'b0);
    queue_byte(CH_NL, 1'b0);
    queue_byte(8'h01, 1'b0);
    queue_byte(CH_NL, 1'b0);
    wait_idle();

    // Directed: the undefined numbering mode, written with all bits set, must
    // skip blank lines; the tab switch alone gives ^I; control and high bytes
    // pass raw; a file start restarts the count mid-stream. Writes to indexes
    // past the register map must change nothing.
    cfg_write(REG_NUMBER_MODE, 32'hFFFF_FFFF);
    cfg_write(REG_SQUEEZE_BLANKS, 32'hFFFF_FFFE);
    cfg_write(REG_CARET_CONTROLS, 32'h0000_0000);
    cfg_write(REG_MARK_LINE_ENDS, 32'hFFFF_FFFE);
    cfg_write(REG_CARET_TABS, 32'hFFFF_FFFF);
    cfg_write(REG_SPARE_LO, $urandom());
    cfg_write(REG_SPARE_HI, 32'hFFFF_FFFF);
    @(negedge clk);
    rx_style = RX_RANDOM;
    sender_max_gap = 0;
    queue_byte(CH_NL, 1'b1);
    queue_byte("a", 1'b0);
    queue_byte(CH_TAB, 1'b0);
    queue_byte(8'h01, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(CH_NL, 1'b0);
    queue_byte("z", 1'b1);
    wait_idle();

    // Random phases. The first three pin down fixed settings (all on, all off, a mix),
    // the rest draw their settings. Each phase stops sending partway until all results
    // are in. In one phase the receiver holds off for a long stretch while the
    // sender keeps offering bytes back to back.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: program_filter(NUM_UNDEF, 1'b1, 1'b1, 1'b1, 1'b1);
        1: program_filter(NUM_NONE, 1'b0, 1'b0, 1'b0, 1'b0);
        2: program_filter(NUM_NONBLANK, 1'b1, 1'b0, 1'b1, 1'b0);
        default: program_filter(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                1'($urandom_range(0, 1)));
      endcase
      rx_style = rx_style_t'(phase % 3);
      sender_max_gap = (phase % 2 == 1) ? 6 : 0;
      if (phase == 3) begin
        sender_max_gap = 0;
        rx_hold_len = 400;
        rx_hold_req++;
      end
      repeat (10) pending_items.push_back(random_text_item());
      wait_for_results();
      repeat (3) pending_items.push_back(random_text_item());
      wait_idle();
    end

    // Counter run: number every line and feed plain newlines so the count
    // carries through each extra digit column up to three digits.
    program_filter(NUM_ALL, 1'b0, 1'b0, 1'b0, 1'b0);
    rx_style = RX_READY;
    sender_max_gap = 0;
    queue_byte(CH_NL, 1'b1);
    repeat (99) queue_byte(CH_NL, 1'b0);
    wait_idle();

    if (mismatches == 0) begin
      $display("PASS text_line_number_and_caret_filter_top");
    end else begin
      $display("FAIL text_line_number_and_caret_filter_top");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/tlcf_pkg.sv
rtl/core/tlcf_front.sv
rtl/core/tlcf_queue.sv
rtl/core/tlcf_back.sv
rtl/core/text_line_number_and_caret_filter_top.sv
tb/sv/testbench.sv
